// ----- design/zbsp_pkg.sv -----
// ----------------------------------------------------------------------------
// zbsp_pkg: shared types and constants of the zero byte segment packer
// Byte lanes, write list entries and the fixed limits of the packing scheme.
// ----------------------------------------------------------------------------
package zbsp_pkg;

  localparam int SEG_BYTES  = 8;    // bytes in a full segment
  localparam int MAX_WRITES = 9;    // most writes one segment can cause
  localparam int CNT_W      = 4;    // holds 0..MAX_WRITES and 0..SEG_BYTES
  localparam int OUT_OFF_W  = 24;   // offset width on the write port
  localparam int BYTE_W     = 8;

  localparam logic [BYTE_W-1:0] RUN_LIMIT = 8'd255;  // run count that closes a run
  localparam logic [CNT_W-1:0]  RAW_MIN   = 4'd6;    // nonzero bytes to stay raw
  localparam logic [CNT_W-1:0]  FULL_SEG  = 4'd8;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // One planned write: either at the reserved count slot or at base + delta.
  typedef struct packed {
    logic  is_slot;
    cnt_t  delta;
    byte_t value;
  } entry_t;

  // All writes caused by one segment, in output order.
  typedef struct packed {
    entry_t [MAX_WRITES-1:0] ent;
    cnt_t                    count;
    logic                    last;
    logic                    ovf;
    logic [OUT_OFF_W-1:0]    plen;
  } wlist_t;

endpackage

// ----- design/zbsp_seg_if.sv -----
// ----------------------------------------------------------------------------
// zbsp_seg_if: segment input channel
// Valid/ready channel carrying one source segment per item.
// ----------------------------------------------------------------------------
interface zbsp_seg_if;
  logic        valid;
  logic        ready;
  logic [63:0] segment_bytes;
  logic [3:0]  byte_count;
  logic        last_segment;

  modport source (output valid, segment_bytes, byte_count, last_segment, input ready);
  modport sink   (input valid, segment_bytes, byte_count, last_segment, output ready);
endinterface

// ----- design/zbsp_wr_if.sv -----
// ----------------------------------------------------------------------------
// zbsp_wr_if: packed byte write channel
// Valid/ready channel carrying one byte write of the packed stream per item.
// ----------------------------------------------------------------------------
interface zbsp_wr_if;
  logic        valid;
  logic        ready;
  logic [23:0] write_offset;
  logic [7:0]  write_byte;
  logic        last_of_item;
  logic        end_of_stream;
  logic [23:0] packed_length;
  logic        overflow;

  modport source (output valid, write_offset, write_byte, last_of_item, end_of_stream,
                  packed_length, overflow, input ready);
  modport sink   (input valid, write_offset, write_byte, last_of_item, end_of_stream,
                  packed_length, overflow, output ready);
endinterface

// ----- design/zbsp_lane.sv -----
// ----------------------------------------------------------------------------
// zbsp_lane: one byte lane
// Flags the lane's byte as a nonzero byte inside the segment's valid length.
// ----------------------------------------------------------------------------
module zbsp_lane (
  input  logic [2:0]        lane_idx,
  input  zbsp_pkg::byte_t   byte_val,
  input  zbsp_pkg::cnt_t    seg_len,
  output logic              nonzero
);
  import zbsp_pkg::*;

  assign nonzero = (CNT_W'(lane_idx) < seg_len) && (byte_val != '0);
endmodule

// ----- design/zbsp_plan.sv -----
// ----------------------------------------------------------------------------
// zbsp_plan: merge stage and packing state
// Combines the lane flags into the write list of a segment and keeps the run
// and offset state that carries from one segment to the next.
// ----------------------------------------------------------------------------
module zbsp_plan #(
  parameter int OFFSET_WIDTH = 24
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   fire,
  input  logic [zbsp_pkg::SEG_BYTES-1:0][7:0]    seg_bytes,
  input  zbsp_pkg::cnt_t                         seg_len,
  input  logic                                   last,
  input  logic [zbsp_pkg::SEG_BYTES-1:0]         nz_lane,
  output zbsp_pkg::wlist_t                       list,
  output logic [OFFSET_WIDTH-1:0]                base,
  output logic [OFFSET_WIDTH-1:0]                slot
);
  import zbsp_pkg::*;

  logic                    run_open, run_open_next;
  byte_t                   run_count, run_count_next;
  logic [OFFSET_WIDTH-1:0] count_slot_offset, count_slot_offset_next;
  logic [OFFSET_WIDTH-1:0] next_offset, next_offset_next;
  logic                    overflow_seen, overflow_seen_next;

  cnt_t                    pos [SEG_BYTES];
  cnt_t                    nz_total;
  cnt_t                    takes;
  cnt_t                    pre;
  cnt_t                    idx;
  logic                    raw;
  logic                    close;
  byte_t                   mask;
  logic [OFFSET_WIDTH:0]   sum;

  assign base = next_offset;
  assign slot = count_slot_offset;

  // Prefix counts of nonzero lanes give each data byte its place.
  always_comb begin
    for (int i = 0; i < SEG_BYTES; i++) begin
      pos[i] = '0;
      for (int j = 0; j < i; j++) begin
        pos[i] = pos[i] + CNT_W'(nz_lane[j]);
      end
    end
    nz_total = pos[SEG_BYTES-1] + CNT_W'(nz_lane[SEG_BYTES-1]);
    mask     = nz_lane;
  end

  always_comb begin
    list                   = '0;
    takes                  = '0;
    pre                    = '0;
    idx                    = '0;
    close                  = 1'b0;
    run_open_next          = run_open;
    run_count_next         = run_count;
    count_slot_offset_next = count_slot_offset;
    raw                    = run_open && (nz_total >= RAW_MIN);

    if (raw) begin
      // Dense segment inside a run: copy raw, maybe close the run.
      for (int i = 0; i < SEG_BYTES; i++) begin
        if (CNT_W'(i) < seg_len) begin
          list.ent[i] = '{is_slot: 1'b0, delta: CNT_W'(i), value: seg_bytes[i]};
        end
      end
      close = (run_count >= (RUN_LIMIT - 8'd1)) || last;
      if (close) begin
        list.ent[seg_len] = '{is_slot: 1'b1, delta: '0, value: run_count + 8'd1};
      end
      list.count     = seg_len + CNT_W'(close);
      takes          = seg_len;
      run_count_next = close ? '0 : run_count + 8'd1;
      run_open_next  = !close;
    end else begin
      if (run_open) begin
        list.ent[0]    = '{is_slot: 1'b1, delta: '0, value: run_count};
        pre            = 4'd1;
        run_open_next  = 1'b0;
        run_count_next = '0;
      end
      if (seg_len != '0) begin
        list.ent[pre] = '{is_slot: 1'b0, delta: '0, value: mask};
        for (int i = 0; i < SEG_BYTES; i++) begin
          if (nz_lane[i]) begin
            idx           = pre + 4'd1 + pos[i];
            list.ent[idx] = '{is_slot: 1'b0, delta: pos[i] + 4'd1, value: seg_bytes[i]};
          end
        end
        takes = nz_total + 4'd1;
        if (nz_total == FULL_SEG && !last) begin
          run_open_next          = 1'b1;
          run_count_next         = '0;
          count_slot_offset_next = next_offset + OFFSET_WIDTH'(SEG_BYTES + 1);
          takes                  = nz_total + 4'd2;
        end
        list.count = pre + nz_total + 4'd1;
      end else begin
        list.count = pre;
      end
    end

    sum                = {1'b0, next_offset} + (OFFSET_WIDTH+1)'(takes);
    overflow_seen_next = overflow_seen | sum[OFFSET_WIDTH];
    next_offset_next   = sum[OFFSET_WIDTH-1:0];
    list.last          = last;
    list.ovf           = overflow_seen_next;
    list.plen          = OUT_OFF_W'(next_offset_next);

    // A stream end closes everything and restarts offsets at zero.
    if (last) begin
      run_open_next    = 1'b0;
      run_count_next   = '0;
      next_offset_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_open          <= 1'b0;
      run_count         <= '0;
      count_slot_offset <= '0;
      next_offset       <= '0;
      overflow_seen     <= 1'b0;
    end else if (fire) begin
      run_open          <= run_open_next;
      run_count         <= run_count_next;
      count_slot_offset <= count_slot_offset_next;
      next_offset       <= next_offset_next;
      overflow_seen     <= overflow_seen_next;
    end
  end
endmodule

// ----- design/zbsp_serializer.sv -----
// ----------------------------------------------------------------------------
// zbsp_serializer: write list buffer and output register
// Holds one segment's write list and hands it out one byte write per cycle unless stalled.
// ----------------------------------------------------------------------------
module zbsp_serializer #(
  parameter int OFFSET_WIDTH = 24
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    fire,
  input  zbsp_pkg::wlist_t        list,
  input  logic [OFFSET_WIDTH-1:0] base,
  input  logic [OFFSET_WIDTH-1:0] slot,
  output logic                    in_ready,
  zbsp_wr_if.source               wr
);
  import zbsp_pkg::*;

  wlist_t                  buf_list;
  logic [OFFSET_WIDTH-1:0] buf_base;
  logic [OFFSET_WIDTH-1:0] buf_slot;
  logic                    buf_valid;
  cnt_t                    idx;

  entry_t                  ent;
  logic                    final_ent;
  logic                    move;
  logic                    buf_done;
  logic                    load;
  logic [OFFSET_WIDTH-1:0] off;

  assign ent       = buf_list.ent[idx];
  assign final_ent = (idx == buf_list.count - 4'd1);
  assign move      = buf_valid && (!wr.valid || wr.ready);
  assign buf_done  = move && final_ent;
  assign in_ready  = !buf_valid || buf_done;
  assign load      = fire && (list.count != '0);
  assign off       = ent.is_slot ? buf_slot : buf_base + OFFSET_WIDTH'(ent.delta);

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      buf_valid <= 1'b1;
      idx       <= '0;
    end else if (buf_done) begin
      buf_valid <= 1'b0;
      idx       <= '0;
    end else if (move) begin
      idx <= idx + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_list <= list;
      buf_base <= base;
      buf_slot <= slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr.valid <= 1'b0;
    end else if (move) begin
      wr.valid <= 1'b1;
    end else if (wr.ready) begin
      wr.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      wr.write_offset  <= OUT_OFF_W'(off);
      wr.write_byte    <= ent.value;
      wr.last_of_item  <= final_ent;
      wr.end_of_stream <= final_ent && buf_list.last;
      wr.packed_length <= buf_list.plen;
      wr.overflow      <= buf_list.ovf;
    end
  end
endmodule

// ----- design/zero_byte_segment_packer.sv -----
// ----------------------------------------------------------------------------
// zero_byte_segment_packer: zero byte packing of a segmented byte stream
// Eight byte lanes, a merge stage and a serializer of one write per cycle unless stalled.
// ----------------------------------------------------------------------------
// Each accepted segment (up to eight bytes) becomes a run of byte writes to
// offsets of the packed stream: a header mask plus the nonzero bytes, or the
// raw bytes while a run of dense segments is open, plus the run count patched
// into its reserved slot when the run closes. A segment causes 1 to 9 writes,
// or none, all through the single byte-wide write port. The whole write list
// of a segment is planned in the cycle it is accepted, so the next segment is
// taken in the same cycle the last write of the current one moves into the
// output register, and a finished write waiting on a stalled sink does not
// hold up the planning of the next segment. packed_length and overflow are
// the same on every write of a segment and show the state after that segment.
// ----------------------------------------------------------------------------
module zero_byte_segment_packer #(
  parameter int OFFSET_WIDTH = 24
) (
  input  logic      clk,
  input  logic      rst,
  zbsp_seg_if.sink  seg,
  zbsp_wr_if.source wr
);
  import zbsp_pkg::*;

  logic                          fire;
  logic                          in_ready;
  cnt_t                          seg_len;
  logic [SEG_BYTES-1:0][7:0]     seg_bytes;
  logic [SEG_BYTES-1:0]          nz_lane;
  wlist_t                        list;
  logic [OFFSET_WIDTH-1:0]       base;
  logic [OFFSET_WIDTH-1:0]       slot;

  assign seg.ready = in_ready;
  assign fire      = seg.valid && in_ready;
  assign seg_bytes = seg.segment_bytes;
  // Byte counts above eight count as a full segment.
  assign seg_len   = seg.byte_count[3] ? FULL_SEG : seg.byte_count;

  // One lane per source byte: nonzero test within the valid length.
  for (genvar g = 0; g < SEG_BYTES; g++) begin : g_lane
    zbsp_lane u_lane (
      .lane_idx (3'(g)),
      .byte_val (seg_bytes[g]),
      .seg_len  (seg_len),
      .nonzero  (nz_lane[g])
    );
  end

  // Merge lanes into a write list and advance run / offset state.
  zbsp_plan #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_plan (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .seg_bytes (seg_bytes),
    .seg_len   (seg_len),
    .last      (seg.last_segment),
    .nz_lane   (nz_lane),
    .list      (list),
    .base      (base),
    .slot      (slot)
  );

  // Hand out the list one write per cycle unless the write port stalls.
  zbsp_serializer #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_ser (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .list     (list),
    .base     (base),
    .slot     (slot),
    .in_ready (in_ready),
    .wr       (wr)
  );
endmodule

// ----- design/zbsp_checker.sv -----
// ----------------------------------------------------------------------------
// zbsp_checker: port checks of the zero byte segment packer
// Watches the write channel for hold, framing, per-segment consistency and a sticky overflow flag.
// ----------------------------------------------------------------------------
module zbsp_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        last_of_item,
  input logic        end_of_stream,
  input logic [23:0] packed_length,
  input logic        overflow
);
  logic        ovf_seen;
  logic        mid_item;
  logic [23:0] prev_plen;
  logic        out_fire;

  assign out_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ovf_seen <= 1'b0;
      mid_item <= 1'b0;
    end else if (out_fire) begin
      ovf_seen <= ovf_seen | overflow;
      mid_item <= !last_of_item;
    end
  end

  always_ff @(posedge clk) begin
    if (out_fire) begin
      prev_plen <= packed_length;
    end
  end

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("write item dropped while stalled");

  a_eos_ends_item: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_stream |-> last_of_item)
    else $error("end_of_stream without last_of_item");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && ovf_seen |-> overflow)
    else $error("overflow flag cleared");

  a_plen_per_item: assert property (@(posedge clk) disable iff (rst)
    out_valid && mid_item |-> packed_length == prev_plen)
    else $error("packed_length changed within one segment");
endmodule

bind zero_byte_segment_packer zbsp_checker u_zbsp_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (wr.valid),
  .out_ready     (wr.ready),
  .last_of_item  (wr.last_of_item),
  .end_of_stream (wr.end_of_stream),
  .packed_length (wr.packed_length),
  .overflow      (wr.overflow)
);
